// ===== src/rgbahd_pkg.sv =====
package rgbahd_pkg;

	// Height limit of the frame
	localparam int MAX_HEIGHT = 4096;
	localparam int CFG_DATA_W = 13;
	localparam int ROW_W      = 12;
	localparam int HGT_W      = 13;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// One input pixel
	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pixel_t;

	// One half-size output pixel
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       row_end;
		logic       frame_end;
	} result_t;

	// Per-channel sums of a horizontal pixel pair, red lowest
	typedef struct packed {
		logic [9:0] alpha;
		logic [9:0] blue;
		logic [9:0] green;
		logic [9:0] red;
	} pair_sum_t;

endpackage

// ===== src/rgba_half_downsampler.sv =====
// rgba_half_downsampler: 2x2 box filter, RGBA8 in, half-size RGBA8 out.
// Throughput: one pixel per cycle unless the output stalls.
// Pixel path: an input stage, then a result register; each 2x2 block's result passes both in turn.
// The line store (MAX_WIDTH/2 x 40 bits) is a single-port RAM, written on even rows, read on odd.
// Reset clears the counters and both valid flags and sets the frame to 256 x 256.
// The line store is not cleared; every entry is written before it is read.
module rgba_half_downsampler
	import rgbahd_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pix_valid,
	output logic                  pix_ready,
	input  pixel_t                pix,
	output logic                  avg_valid,
	input  logic                  avg_ready,
	output result_t               avg,
	input  logic                  wr_en,
	input  cfg_reg_t              wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int DEPTH = MAX_WIDTH / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);

	// Configuration and position state
	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [XW-1:0]         col_q;
	logic [ROW_W-1:0]      row_q;
	pixel_t                held_q;

	// Line store
	pair_sum_t             line_mem [DEPTH];

	// Stage 1
	logic                  valid_s1;
	pair_sum_t             pair_s1, stored_s1;
	logic                  row_end_s1, frame_end_s1;

	// Result register
	logic                  out_valid_q;
	result_t               out_q;

	logic                  accept, advance;
	logic [WW-1:0]         w_eff, col_next, col_half;
	logic [HGT_W-1:0]      h_eff, row_next, row_half;
	logic [AW-1:0]         slot;
	pair_sum_t             pair;
	logic                  odd_col, odd_row, in_rows, do_write, do_emit;
	logic                  last_col, last_row;
	logic [10:0]           sum_r, sum_g, sum_b, sum_a;

	// Effective frame size: zero reads as one, large values saturate
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HGT_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	// Handshake: result register frees when taken, stage 1 when it can move on
	assign advance   = !out_valid_q || avg_ready;
	assign pix_ready = !valid_s1 || advance;
	assign accept    = pix_valid && pix_ready;

	// Position decode and pair sum
	always_comb begin
		col_next  = WW'(col_q) + WW'(1);
		row_next  = HGT_W'(row_q) + HGT_W'(1);
		col_half  = WW'(col_q) >> 1;
		row_half  = HGT_W'(row_q) >> 1;
		slot      = AW'(col_q >> 1);
		odd_col   = col_q[0];
		odd_row   = row_q[0];
		in_rows   = row_half < (h_eff >> 1);
		do_write  = odd_col && !odd_row && in_rows;
		do_emit   = odd_col && odd_row && in_rows;
		last_col  = col_half == ((w_eff >> 1) - WW'(1));
		last_row  = row_half == ((h_eff >> 1) - HGT_W'(1));
		pair.red   = {2'b0, held_q.red_in}   + {2'b0, pix.red_in};
		pair.green = {2'b0, held_q.green_in} + {2'b0, pix.green_in};
		pair.blue  = {2'b0, held_q.blue_in}  + {2'b0, pix.blue_in};
		pair.alpha = {2'b0, held_q.alpha_in} + {2'b0, pix.alpha_in};
	end

	// Counters, held pixel and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DATA_W'(256);
			height_q <= CFG_DATA_W'(256);
			col_q    <= '0;
			row_q    <= '0;
			held_q   <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:  width_q  <= wr_data;
				REG_IMAGE_HEIGHT: height_q <= wr_data;
				default:          ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!odd_col) begin
				held_q <= pix;
			end
			if (col_next >= w_eff) begin
				col_q <= '0;
				row_q <= (row_next >= h_eff) ? '0 : ROW_W'(row_next);
			end else begin
				col_q <= XW'(col_next);
			end
		end
	end

	// Line store: write on even rows, registered read on every accepted pixel, used on odd rows
	always_ff @(posedge clk) begin
		if (accept) begin
			if (do_write) begin
				line_mem[slot] <= pair;
			end
			stored_s1 <= line_mem[slot];
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1      <= pair;
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	// Stage 1 valid: only transactions that produce a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= accept && do_emit;
		end
	end

	// Four-value sums
	always_comb begin
		sum_r = {1'b0, stored_s1.red}   + {1'b0, pair_s1.red};
		sum_g = {1'b0, stored_s1.green} + {1'b0, pair_s1.green};
		sum_b = {1'b0, stored_s1.blue}  + {1'b0, pair_s1.blue};
		sum_a = {1'b0, stored_s1.alpha} + {1'b0, pair_s1.alpha};
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q.red_out   <= sum_r[9:2];
			out_q.green_out <= sum_g[9:2];
			out_q.blue_out  <= sum_b[9:2];
			out_q.alpha_out <= sum_a[9:2];
			out_q.row_end   <= row_end_s1;
			out_q.frame_end <= frame_end_s1;
		end
	end

	assign avg_valid = out_valid_q;
	assign avg       = out_q;

endmodule

// ===== src/rgbahd_checker.sv =====
module rgbahd_checker
	import rgbahd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pix_valid,
	input  logic    pix_ready,
	input  logic    avg_valid,
	input  logic    avg_ready,
	input  result_t avg
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && !avg_ready |=> avg_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid && !avg_ready |=> $stable(avg))
		else $error("result payload changed while stalled");

	// The last pixel of a frame also closes its row
	assert property (@(posedge clk) disable iff (!arst_n)
		avg_valid |-> (!avg.frame_end || avg.row_end))
		else $error("frame end without row end");

	// With no input transaction and a free output, stage 1 empties and then the result register, draining the pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pix_valid && pix_ready) && avg_ready ##1
		!(pix_valid && pix_ready) && avg_ready |=> !avg_valid)
		else $error("result appeared without an input transaction");

endmodule

bind rgba_half_downsampler rgbahd_checker u_rgbahd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.avg_valid (avg_valid),
	.avg_ready (avg_ready),
	.avg       (avg)
);
